// ----- sv/mmtb_pkg.sv -----
package mmtb_pkg;

  localparam int MAX_CELLS  = 64;
  localparam int FEAT_W     = 16;
  localparam int NUM_FEAT   = 4;
  localparam int IN_W       = 16;
  localparam int CUT_W      = 7;
  localparam int LVL_W      = 3;
  localparam int CELL_IDX_W = 6;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;
  localparam int CNT_W      = $clog2(MAX_CELLS + 1);
  localparam int ADDR_W     = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
  localparam int PROD_W     = FEAT_W + 1 + CUT_W;

  localparam logic [CUT_W-1:0] PCT_SCALE    = 7'd100;
  localparam logic [CUT_W-1:0] LOW_CUT_RST  = 7'd33;
  localparam logic [CUT_W-1:0] HIGH_CUT_RST = 7'd66;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LOW_CUT  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_CUT = 1'd1;

  // level codes: one-hot, with LVL_NONE as all zeros
  localparam logic [LVL_W-1:0] LVL_NONE = 3'd0;
  localparam logic [LVL_W-1:0] LVL_LOW  = 3'd1;
  localparam logic [LVL_W-1:0] LVL_MED  = 3'd2;
  localparam logic [LVL_W-1:0] LVL_HIGH = 3'd4;

  typedef logic signed [FEAT_W-1:0] feat_t;
  typedef logic [NUM_FEAT-1:0][FEAT_W-1:0] featv_t;
  typedef logic [CUT_W-1:0] cut_t;
  typedef logic [IN_W-1:0] in_feat_t;
  typedef logic [LVL_W-1:0] lvl_t;

  typedef struct packed {
    logic load;   // take the input cell
    logic rd;     // read cell store at the emit index
    logic fill;   // capture a result into the output register
    logic next;   // advance the emit index
    logic done;   // close the set
  } cmd_t;

  typedef struct packed {
    logic last;   // emit index points at the final stored cell
  } status_t;

endpackage

// ----- sv/mmtb_ctrl.sv -----
module mmtb_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              last_cell_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output mmtb_pkg::cmd_t    cmd_o,
  input  mmtb_pkg::status_t status_i
);
  import mmtb_pkg::*;

  typedef enum logic [3:0] {
    ST_LOAD = 4'b0001,
    ST_READ = 4'b0010,
    ST_FILL = 4'b0100,
    ST_SEND = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   in_acc, out_acc;

  assign in_stall_o  = (state_q != ST_LOAD);
  assign out_valid_o = (state_q == ST_SEND);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_acc     = out_valid_o && !out_stall_i;

  always_comb begin
    cmd_o      = '0;
    cmd_o.load = in_acc;
    cmd_o.rd   = (state_q == ST_READ);
    cmd_o.fill = (state_q == ST_FILL);
    cmd_o.next = out_acc && !status_i.last;
    cmd_o.done = out_acc && status_i.last;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_LOAD: begin
        if (in_acc && last_cell_i) state_d = ST_READ;
      end
      ST_READ: state_d = ST_FILL;
      ST_FILL: state_d = ST_SEND;
      ST_SEND: begin
        if (out_acc) state_d = status_i.last ? ST_LOAD : ST_READ;
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  a_last_starts_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && last_cell_i) |=> (state_q == ST_READ))
    else $error("last cell did not start emission");

  a_final_closes_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && status_i.last) |=> (state_q == ST_LOAD))
    else $error("final result did not reopen loading");

  a_no_load_in_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !cmd_o.load)
    else $error("cell loaded during emission");

endmodule

// ----- sv/mmtb_datapath.sv -----
module mmtb_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  mmtb_pkg::cmd_t                 cmd_i,
  output mmtb_pkg::status_t              status_o,
  input  mmtb_pkg::in_feat_t             density_i,
  input  mmtb_pkg::in_feat_t             speed_i,
  input  mmtb_pkg::in_feat_t             heading_i,
  input  mmtb_pkg::in_feat_t             goal_distance_i,
  input  logic                           cfg_we_i,
  input  logic [mmtb_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [mmtb_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output logic [mmtb_pkg::CELL_IDX_W-1:0] cell_index_o,
  output mmtb_pkg::lvl_t                 density_level_o,
  output mmtb_pkg::lvl_t                 speed_level_o,
  output mmtb_pkg::lvl_t                 heading_level_o,
  output mmtb_pkg::lvl_t                 goal_level_o,
  output logic                           last_result_o
);
  import mmtb_pkg::*;

  featv_t              mem [MAX_CELLS];
  featv_t              rd_q;
  featv_t              cell_in;
  featv_t              min_q, max_q, min_d, max_d;
  logic [CNT_W-1:0]    count_q;
  logic [ADDR_W-1:0]   k_q;
  logic                full;
  logic                wr;
  cut_t                low_cut_q, high_cut_q;
  logic [NUM_FEAT-1:0][LVL_W-1:0] lvl;
  logic [NUM_FEAT-1:0][LVL_W-1:0] lvl_q;
  logic [CELL_IDX_W-1:0] idx_q;
  logic                last_q;

  function automatic lvl_t level_of(input feat_t x, input feat_t mn, input feat_t mx,
                                    input cut_t lc, input cut_t hc);
    logic [FEAT_W:0]   r;
    logic [FEAT_W:0]   dx;
    logic [PROD_W-1:0] d;
    logic [PROD_W-1:0] lo;
    logic [PROD_W-1:0] hi;
    lvl_t              v;
    r  = {mx[FEAT_W-1], mx} - {mn[FEAT_W-1], mn};
    dx = {x[FEAT_W-1], x} - {mn[FEAT_W-1], mn};
    d  = PROD_W'(dx) * PROD_W'(PCT_SCALE);
    lo = PROD_W'(r) * PROD_W'(lc);
    hi = PROD_W'(r) * PROD_W'(hc);
    v  = LVL_NONE;
    if (mx <= mn) begin
      v = LVL_LOW;  // zero range
    end else begin
      if (d < lo) v = LVL_LOW;
      if (d > hi) v = LVL_HIGH;
      if (d < hi && d > lo) v = LVL_MED;
    end
    return v;
  endfunction

  assign cell_in[0] = density_i[FEAT_W-1:0];
  assign cell_in[1] = speed_i[FEAT_W-1:0];
  assign cell_in[2] = heading_i[FEAT_W-1:0];
  assign cell_in[3] = goal_distance_i[FEAT_W-1:0];

  assign full = (count_q == CNT_W'(MAX_CELLS));
  assign wr   = cmd_i.load && !full;
  assign status_o.last = ((CNT_W'(k_q) + CNT_W'(1)) == count_q);

  // running range, seeded from the first cell of a set
  always_comb begin
    min_d = min_q;
    max_d = max_q;
    for (int f = 0; f < NUM_FEAT; f++) begin
      if (count_q == '0) begin
        min_d[f] = cell_in[f];
        max_d[f] = cell_in[f];
      end else begin
        if (feat_t'(cell_in[f]) < feat_t'(min_q[f])) min_d[f] = cell_in[f];
        if (feat_t'(cell_in[f]) > feat_t'(max_q[f])) max_d[f] = cell_in[f];
      end
    end
  end

  always_comb begin
    for (int f = 0; f < NUM_FEAT; f++) begin
      lvl[f] = level_of(feat_t'(rd_q[f]), feat_t'(min_q[f]), feat_t'(max_q[f]),
                        low_cut_q, high_cut_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) mem[count_q[ADDR_W-1:0]] <= cell_in;
    if (cmd_i.rd) rd_q <= mem[k_q];
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      min_q <= min_d;
      max_q <= max_d;
    end
    if (cmd_i.fill) begin
      lvl_q  <= lvl;
      idx_q  <= CELL_IDX_W'(k_q);
      last_q <= status_o.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      k_q     <= '0;
    end else begin
      if (cmd_i.done) begin
        count_q <= '0;
        k_q     <= '0;
      end else begin
        if (wr) count_q <= count_q + CNT_W'(1);
        if (cmd_i.next) k_q <= k_q + ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_cut_q  <= LOW_CUT_RST;
      high_cut_q <= HIGH_CUT_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_LOW_CUT:  low_cut_q  <= cfg_data_i;
        REG_HIGH_CUT: high_cut_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cell_index_o    = idx_q;
  assign density_level_o = lvl_q[0];
  assign speed_level_o   = lvl_q[1];
  assign heading_level_o = lvl_q[2];
  assign goal_level_o    = lvl_q[3];
  assign last_result_o   = last_q;

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_CELLS))
    else $error("cell count past capacity");

  a_read_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rd |-> (count_q != '0) && (CNT_W'(k_q) < count_q))
    else $error("read beyond stored cells");

  a_done_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.done |=> (count_q == '0) && (k_q == '0))
    else $error("set not cleared after final result");

endmodule

// ----- sv/min_max_tercile_binarizer_core.sv -----
// Loads a set of cells at one per cycle while keeping the running minimum and
// maximum of each of the four features. The cell flagged last_cell closes the
// set; input then stalls while one result per stored cell goes out in load
// order, one at a time. Each passes the cell store read, the level compare
// against the cuts and the output register, and is held through any output
// stall. Up to 64 cells are kept; extra cells are dropped but a
// dropped cell flagged last still closes the set. low_cut (index 0) and
// high_cut (index 1) are in hundredths and take effect from the next result.
module min_max_tercile_binarizer_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  mmtb_pkg::in_feat_t              density_i,
  input  mmtb_pkg::in_feat_t              speed_i,
  input  mmtb_pkg::in_feat_t              heading_i,
  input  mmtb_pkg::in_feat_t              goal_distance_i,
  input  logic                            last_cell_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [mmtb_pkg::CELL_IDX_W-1:0] cell_index_o,
  output mmtb_pkg::lvl_t                  density_level_o,
  output mmtb_pkg::lvl_t                  speed_level_o,
  output mmtb_pkg::lvl_t                  heading_level_o,
  output mmtb_pkg::lvl_t                  goal_level_o,
  output logic                            last_result_o,
  input  logic                            cfg_we_i,
  input  logic [mmtb_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [mmtb_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import mmtb_pkg::*;

  cmd_t    cmd;
  status_t status;

  mmtb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .last_cell_i (last_cell_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  mmtb_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .density_i       (density_i),
    .speed_i         (speed_i),
    .heading_i       (heading_i),
    .goal_distance_i (goal_distance_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .cell_index_o    (cell_index_o),
    .density_level_o (density_level_o),
    .speed_level_o   (speed_level_o),
    .heading_level_o (heading_level_o),
    .goal_level_o    (goal_level_o),
    .last_result_o   (last_result_o)
  );

endmodule
